### hdl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define BFQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfq assertion failed");

// next-cycle implication, held off during reset
`define BFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfq assertion failed");

`endif

### hdl/bfq_pkg.sv
// shared widths, operation codes and status codes of the bounded fifo
package bfq_pkg;

    localparam int DATA_W    = 64;
    localparam int OP_W      = 3;
    localparam int ST_W      = 3;
    localparam int OCC_W     = 7;
    localparam int CAP_W     = 7;
    localparam int DEPTH_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [ST_W-1:0]   status_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [OCC_W-1:0]  occ_t;
    typedef logic [CAP_W-1:0]  cap_t;

    localparam op_t OP_PUSH     = 3'd0;
    localparam op_t OP_POP      = 3'd1;
    localparam op_t OP_POP_PUSH = 3'd2;
    localparam op_t OP_REMOVE   = 3'd3;
    localparam op_t OP_CLEAR    = 3'd4;

    localparam status_t ST_OK             = 3'd0;
    localparam status_t ST_FULL           = 3'd1;
    localparam status_t ST_EMPTY          = 3'd2;
    localparam status_t ST_EMPTY_INSERTED = 3'd3;
    localparam status_t ST_NO_MATCH       = 3'd4;

endpackage

### hdl/bfq_ifs.sv
// request and response channel interfaces of the bounded fifo
interface bfq_req_if;
    import bfq_pkg::*;

    logic  valid;
    logic  ready;
    op_t   operation;
    data_t value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface bfq_rsp_if;
    import bfq_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    data_t   popped_value;
    logic    popped_valid;
    occ_t    occupancy;

    modport source (output valid, output status, output popped_value, output popped_valid,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input popped_value, input popped_valid,
                    input occupancy, output ready);
endinterface

### hdl/bfq_ram.sv
// member store: one write port, one registered read port
module bfq_ram #(
    parameter int DEPTH = bfq_pkg::DEPTH_DEF,
    parameter int AW    = 6
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [bfq_pkg::DATA_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [bfq_pkg::DATA_W-1:0] rdata
);
    import bfq_pkg::*;

    data_t mem [DEPTH];
    data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/bounded_fifo_with_member_removal_core.sv
// bounded fifo of 64-bit members with capacity register and remove-by-value
// push, pop, pop-push, clear and unknown codes: taken in idle, result registered from exec once the output is free
// remove: exec, then the walk state reads one store entry per cycle; entries after the match are moved
// one item in work at a time; result register frees the input
// reset (async, active low) empties the queue, capacity returns to 64
// store contents are not cleared; the walk reads only entries holding members
module bounded_fifo_with_member_removal_core #(
    parameter int DEPTH = bfq_pkg::DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bfq_req_if.sink                   req,
    bfq_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [bfq_pkg::CAP_W-1:0] cfg_wdata
);
    import bfq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((AW > CW) ? AW : CW) + 1;
    localparam int KW = ((CW > CAP_W) ? CW : CAP_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    cap_t          cap_reg;
    op_t           op_reg;
    data_t         value_reg;

    logic    out_valid_reg;
    status_t out_status_reg;
    data_t   out_pval_reg;
    logic    out_pvalid_reg;
    occ_t    out_occ_reg;

    logic          emit;
    status_t       res_status;
    data_t         res_pval;
    logic          res_pvalid;
    logic          can_emit;
    logic          is_empty;
    logic          is_full;
    logic          last;
    logic          hit;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    data_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    data_t         mem_rdata;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(offset);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    bfq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bfq_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign can_emit  = !out_valid_reg || rsp.ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (KW'(count_reg) >= KW'(cap_reg)) || (count_reg == CW'(DEPTH));
    assign last      = (idx_reg == count_reg - CW'(1));
    assign hit       = !found_reg && (mem_rdata == value_reg);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        emit       = 1'b0;
        res_status = ST_OK;
        res_pval   = '0;
        res_pvalid = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = slot_of(head_reg, count_reg);
        mem_wdata  = value_reg;
        mem_re     = 1'b0;
        mem_raddr  = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // oldest member is fetched ahead of every item
                mem_re = 1'b1;
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (can_emit)
                        begin
                            emit = 1'b1;
                            if (is_full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end
                    OP_POP:
                    begin
                        if (can_emit)
                        begin
                            emit = 1'b1;
                            if (is_empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                res_pval   = mem_rdata;
                                res_pvalid = 1'b1;
                                head_next  = slot_of(head_reg, CW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                    OP_POP_PUSH:
                    begin
                        if (can_emit)
                        begin
                            emit   = 1'b1;
                            mem_we = 1'b1;
                            if (is_empty)
                            begin
                                res_status = ST_EMPTY_INSERTED;
                                count_next = CW'(1);
                            end
                            else
                            begin
                                res_pval   = mem_rdata;
                                res_pvalid = 1'b1;
                                head_next  = slot_of(head_reg, CW'(1));
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (is_empty)
                        begin
                            if (can_emit)
                            begin
                                emit       = 1'b1;
                                res_status = ST_EMPTY;
                            end
                        end
                        else
                        begin
                            // read data still holds the oldest member
                            state_next = S_WALK;
                            idx_next   = '0;
                            found_next = 1'b0;
                        end
                    end
                    OP_CLEAR:
                    begin
                        if (can_emit)
                        begin
                            emit       = 1'b1;
                            head_next  = '0;
                            count_next = '0;
                        end
                    end
                    default:
                    begin
                        if (can_emit)
                        begin
                            emit = 1'b1;
                        end
                    end
                endcase
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                // after the match every member moves one slot toward the head
                mem_waddr = slot_of(head_reg, idx_reg - CW'(1));
                mem_wdata = mem_rdata;
                if (!last)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = slot_of(head_reg, idx_reg + CW'(1));
                    mem_we     = found_reg;
                    found_next = found_reg || hit;
                    idx_next   = idx_reg + CW'(1);
                end
                else if (can_emit)
                begin
                    emit       = 1'b1;
                    mem_we     = found_reg;
                    state_next = S_IDLE;
                    if (found_reg || hit)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        res_status = ST_NO_MATCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg    <= req.operation;
            value_reg <= req.value;
        end
        if (emit)
        begin
            out_status_reg <= res_status;
            out_pval_reg   <= res_pval;
            out_pvalid_reg <= res_pvalid;
            out_occ_reg    <= OCC_W'(count_next);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.popped_value = out_pval_reg;
    assign rsp.popped_valid = out_pvalid_reg;
    assign rsp.occupancy    = out_occ_reg;

endmodule

### hdl/bfq_checker.sv
// port-level checks of the bounded fifo and their binding to the top level
`include "assert_macros.svh"

module bfq_checker #(
    parameter int DEPTH = bfq_pkg::DEPTH_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [bfq_pkg::ST_W-1:0]   rsp_status,
    input logic [bfq_pkg::DATA_W-1:0] rsp_popped_value,
    input logic                       rsp_popped_valid,
    input logic [bfq_pkg::OCC_W-1:0]  rsp_occupancy
);
    import bfq_pkg::*;

    localparam bit OCC_FITS = (DEPTH < (1 << OCC_W));

    // one item in work at a time
    `BFQ_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)

    `BFQ_ASSERT_NOW(a_pop_is_ok, clk, rst_n, rsp_valid && rsp_popped_valid, rsp_status == ST_OK)

    `BFQ_ASSERT_NOW(a_no_pop_zero, clk, rst_n, rsp_valid && !rsp_popped_valid, rsp_popped_value == '0)

    `BFQ_ASSERT_NOW(a_occ_bound, clk, rst_n, rsp_valid && OCC_FITS, 32'(rsp_occupancy) <= DEPTH)

    `BFQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

endmodule

bind bounded_fifo_with_member_removal_core bfq_checker #(
    .DEPTH (DEPTH)
) u_bfq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_popped_value (rsp.popped_value),
    .rsp_popped_valid (rsp.popped_valid),
    .rsp_occupancy    (rsp.occupancy)
);
